// File: sv/tdasa_pkg.sv
// Package for the top-down address space allocator.
// Types and codes shared by the cell row and the top level; no dependencies.
package tdasa_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_SWITCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_FULL     = 2'd2,
    ST_UNKNOWN  = 2'd3
  } status_e;

  // Shift control for the cells of the row; each cell gets its own code.
  typedef enum logic [1:0] {
    SH_HOLD  = 2'd0,
    SH_UP    = 2'd1,
    SH_DOWN  = 2'd2
  } shift_e;

  // Register indexes on the configuration port.
  localparam logic [0:0] REG_SPACE_BEGIN = 1'b0;
  localparam logic [0:0] REG_SPACE_END   = 1'b1;

endpackage

// File: sv/tdasa_cell.sv
// One table slot of the allocator row: holds base, size and handle of a range.
// Depends on tdasa_pkg for the shift codes.
module tdasa_cell #(
  parameter int PAGE_BITS   = 20,
  parameter int HANDLE_BITS = 8
) (
  input  logic                   clk_i,
  input  tdasa_pkg::shift_e      shift_i,
  input  logic                   load_i,
  input  logic                   sethandle_i,
  input  logic [PAGE_BITS-1:0]   new_base_i,
  input  logic [PAGE_BITS:0]     new_pages_i,
  input  logic [HANDLE_BITS-1:0] new_handle_i,
  input  logic [PAGE_BITS-1:0]   below_base_i,
  input  logic [PAGE_BITS:0]     below_pages_i,
  input  logic [HANDLE_BITS-1:0] below_handle_i,
  input  logic [PAGE_BITS-1:0]   above_base_i,
  input  logic [PAGE_BITS:0]     above_pages_i,
  input  logic [HANDLE_BITS-1:0] above_handle_i,
  output logic [PAGE_BITS-1:0]   base_o,
  output logic [PAGE_BITS:0]     pages_o,
  output logic [HANDLE_BITS-1:0] handle_o
);

  logic [PAGE_BITS-1:0]   base_q;
  logic [PAGE_BITS:0]     pages_q;
  logic [HANDLE_BITS-1:0] handle_q;

  // Load wins; otherwise take from a neighbor, rewrite the handle, or keep the entry.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      base_q   <= new_base_i;
      pages_q  <= new_pages_i;
      handle_q <= new_handle_i;
    end else if (shift_i == tdasa_pkg::SH_UP) begin
      base_q   <= below_base_i;
      pages_q  <= below_pages_i;
      handle_q <= below_handle_i;
    end else if (shift_i == tdasa_pkg::SH_DOWN) begin
      base_q   <= above_base_i;
      pages_q  <= above_pages_i;
      handle_q <= above_handle_i;
    end else if (sethandle_i) begin
      handle_q <= new_handle_i;
    end
  end

  assign base_o   = base_q;
  assign pages_o  = pages_q;
  assign handle_o = handle_q;

endmodule

// File: sv/top_down_address_space_allocator_core.sv
// Top level of the top-down address space allocator: control FSM, APB port and cell row.
// Depends on tdasa_pkg and tdasa_cell.
// Allocate scans the gaps from the top entry down, one gap per cycle, then shifts the table and
// raises the strobe; a full table answers at once from the scan. Free scans, then shifts the table.
// One item at a time: busy rises after acceptance and stays high through the strobe; next accept in the cycle after it.
// Reset clears the entry count, the space registers and the FSM; table contents stay undefined.
module top_down_address_space_allocator_core #(
  parameter int MAX_RANGES  = 16,
  parameter int PAGE_BITS   = 20,
  parameter int HANDLE_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             operation_i,
  input  logic [HANDLE_BITS-1:0] block_handle_i,
  input  logic [HANDLE_BITS-1:0] old_handle_i,
  input  logic [PAGE_BITS:0]     alloc_pages_i,
  input  logic [PAGE_BITS-1:0]   guard_pages_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [PAGE_BITS-1:0]   range_base_o,
  output logic [PAGE_BITS:0]     range_pages_o
);

  localparam int IW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int SW = PAGE_BITS + 3; // signed width for gap math

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q;
  logic [CW-1:0]          idx_q;
  logic [PAGE_BITS-1:0]   begin_q;
  logic [PAGE_BITS:0]     end_q;
  logic [1:0]             op_q;
  logic [HANDLE_BITS-1:0] hnd_q, old_q;
  logic [PAGE_BITS:0]     size_q;
  logic [PAGE_BITS-1:0]   guard_q;
  logic signed [SW-1:0]   limit_q;
  logic [1:0]             st_q;
  logic [PAGE_BITS-1:0]   rbase_q;
  logic [PAGE_BITS:0]     rpages_q;
  logic [CW-1:0]          pos_q;    // target slot for insert/remove
  logic                   ins_q;    // insert (else remove) during shift
  logic                   done_q;

  logic [PAGE_BITS-1:0]   cb [MAX_RANGES];
  logic [PAGE_BITS:0]     cp [MAX_RANGES];
  logic [HANDLE_BITS-1:0] ch [MAX_RANGES];

  localparam logic REG_IDX1 = tdasa_pkg::REG_SPACE_END;

  // APB: writes on access phase, reads return the space registers
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IDX1) prdata[PAGE_BITS:0] = end_q;
    else prdata[PAGE_BITS-1:0] = begin_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_q <= '0;
      end_q   <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == tdasa_pkg::REG_SPACE_BEGIN) begin_q <= pwdata[PAGE_BITS-1:0];
      else end_q <= pwdata[PAGE_BITS:0];
    end
  end

  // Currently scanned entry; idx_q counts down for alloc, up for lookups
  logic [IW-1:0]          sel;
  logic signed [SW-1:0]   e_b, e_end, need, gap_base;
  logic                   fits;
  always_comb begin
    sel      = (op_q == tdasa_pkg::OP_ALLOC) ? IW'(idx_q - CW'(1)) : idx_q[IW-1:0];
    e_b      = SW'(cb[sel]);
    e_end    = e_b + SW'(cp[sel]);
    need     = SW'(size_q) + SW'(guard_q);
    gap_base = e_end + SW'(guard_q);
    fits     = (limit_q - e_end >= need) && (gap_base < (SW'(1) <<< PAGE_BITS));
  end

  // Fallback placement at space_begin once no gap above fits
  logic signed [SW-1:0] sb;
  logic                 low_ok;
  always_comb begin
    sb = SW'(begin_q);
    if (count_q != '0) low_ok = !(SW'(cb[0]) < sb + need);
    else low_ok = !(SW'(end_q) < sb + SW'(size_q));
  end

  logic [IW:0] rem_last;
  assign rem_last = (IW+1)'(count_q) - (IW+1)'(1);

  // Control FSM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start) begin
          op_q    <= operation_i;
          hnd_q   <= block_handle_i;
          old_q   <= old_handle_i;
          size_q  <= alloc_pages_i;
          guard_q <= guard_pages_i;
          limit_q <= SW'(end_q);
          idx_q   <= (operation_i == tdasa_pkg::OP_ALLOC) ? count_q : '0;
        end
        S_SCAN: begin
          if (op_q == tdasa_pkg::OP_ALLOC) begin
            if (count_q == CW'(MAX_RANGES)) begin
              st_q <= tdasa_pkg::ST_FULL; rbase_q <= '0; rpages_q <= size_q;
              done_q <= 1'b1;
            end else if (idx_q == '0) begin
              if (low_ok) begin
                st_q <= tdasa_pkg::ST_OK; rbase_q <= begin_q; rpages_q <= size_q;
                pos_q <= '0; ins_q <= 1'b1;
              end else begin
                st_q <= tdasa_pkg::ST_NO_SPACE; rbase_q <= '0; rpages_q <= size_q;
                done_q <= 1'b1;
              end
            end else if (fits) begin
              st_q <= tdasa_pkg::ST_OK; rbase_q <= gap_base[PAGE_BITS-1:0];
              rpages_q <= size_q; pos_q <= idx_q; ins_q <= 1'b1;
            end else begin
              limit_q <= e_b - SW'(guard_q);
              idx_q   <= idx_q - CW'(1);
            end
          end else if (op_q == tdasa_pkg::OP_NONE || idx_q >= count_q) begin
            st_q <= tdasa_pkg::ST_UNKNOWN; rbase_q <= '0; rpages_q <= '0;
            done_q <= 1'b1;
          end else if (ch[sel] == ((op_q == tdasa_pkg::OP_FREE) ? hnd_q : old_q)) begin
            st_q <= tdasa_pkg::ST_OK; rbase_q <= cb[sel]; rpages_q <= cp[sel];
            pos_q <= idx_q; ins_q <= 1'b0;
            if (op_q == tdasa_pkg::OP_SWITCH) done_q <= 1'b1;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        S_SHIFT: begin
          count_q <= ins_q ? count_q + CW'(1) : count_q - CW'(1);
          done_q  <= 1'b1;
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  // Scan finishes when a result is settled; alloc/free then shift the row on success
  logic scan_end, scan_shift;
  always_comb begin
    scan_end = 1'b0; scan_shift = 1'b0;
    if (op_q == tdasa_pkg::OP_ALLOC) begin
      if (count_q == CW'(MAX_RANGES)) scan_end = 1'b1;
      else if (idx_q == '0) begin scan_end = 1'b1; scan_shift = low_ok; end
      else if (fits) begin scan_end = 1'b1; scan_shift = 1'b1; end
    end else if (op_q == tdasa_pkg::OP_NONE || idx_q >= count_q) scan_end = 1'b1;
    else if (ch[sel] == ((op_q == tdasa_pkg::OP_FREE) ? hnd_q : old_q)) begin
      scan_end = 1'b1; scan_shift = (op_q == tdasa_pkg::OP_FREE);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start) state_d = S_SCAN;
      S_SCAN:  if (scan_end) state_d = scan_shift ? S_SHIFT : S_DONE;
      S_SHIFT: state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Switch rewrites the handle in place at the end of the scan
  logic sw_hit;
  assign sw_hit = (state_q == S_SCAN) && (op_q == tdasa_pkg::OP_SWITCH) && scan_end &&
                  (idx_q < count_q);

  // Cell row: insert opens a hole at pos by shifting up, remove closes it
  for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
    tdasa_pkg::shift_e sh;
    logic              ld;
    always_comb begin
      sh = tdasa_pkg::SH_HOLD;
      ld = 1'b0;
      if (state_q == S_SHIFT) begin
        if (ins_q) begin
          if ((IW+1)'(g) == (IW+1)'(pos_q)) ld = 1'b1;
          else if ((IW+1)'(g) > (IW+1)'(pos_q)) sh = tdasa_pkg::SH_UP;
        end else if ((IW+1)'(g) >= (IW+1)'(pos_q) && (IW+1)'(g) < rem_last) begin
          sh = tdasa_pkg::SH_DOWN;
        end
      end
    end
    tdasa_cell #(.PAGE_BITS(PAGE_BITS), .HANDLE_BITS(HANDLE_BITS)) u_cell (
      .clk_i          (clk_i),
      .shift_i        (sh),
      .load_i         (ld),
      .sethandle_i    (sw_hit && (sel == IW'(g))),
      .new_base_i     (rbase_q),
      .new_pages_i    (rpages_q),
      .new_handle_i   (hnd_q),
      .below_base_i   (cb[(g == 0) ? 0 : g-1]),
      .below_pages_i  (cp[(g == 0) ? 0 : g-1]),
      .below_handle_i (ch[(g == 0) ? 0 : g-1]),
      .above_base_i   (cb[(g == MAX_RANGES-1) ? g : g+1]),
      .above_pages_i  (cp[(g == MAX_RANGES-1) ? g : g+1]),
      .above_handle_i (ch[(g == MAX_RANGES-1) ? g : g+1]),
      .base_o         (cb[g]),
      .pages_o        (cp[g]),
      .handle_o       (ch[g])
    );
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = st_q;
  assign range_base_o  = rbase_q;
  assign range_pages_o = rpages_q;

endmodule

// File: sv/tdasa_checker.sv
// Port-level checker for the allocator core, bound to the top level.
// Depends on tdasa_pkg for status codes.
module tdasa_checker #(
  parameter int PAGE_BITS = 20
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 done_o,
  input logic [1:0]           status_o,
  input logic [PAGE_BITS-1:0] range_base_o
);

  // An accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("not busy after accept");

  // A result appears only while busy
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe while idle");

  // Strobe is a single cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe too long");

  // Failures report base zero
  a_fail_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != tdasa_pkg::ST_OK) |-> (range_base_o == '0))
    else $error("nonzero base on failure");

endmodule

bind top_down_address_space_allocator_core tdasa_checker #(.PAGE_BITS(PAGE_BITS)) u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .range_base_o (range_base_o)
);
